// ----- rtl/core/mcl_pkg.sv -----
// ----------------------------------------------------------------------------
// Command line lexer package
// Shared types and codes for the command line lexer: the byte class made by
// the front end, the queued request, and the tagged result.
// ----------------------------------------------------------------------------
package mcl_pkg;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] ROLE_SKIP  = 3'd0;
  localparam logic [2:0] ROLE_TOKEN = 3'd1;
  localparam logic [2:0] ROLE_OPER  = 3'd2;
  localparam logic [2:0] ROLE_OPTN  = 3'd3;
  localparam logic [2:0] ROLE_OPTP  = 3'd4;
  localparam logic [2:0] ROLE_PAR   = 3'd5;

  localparam logic [1:0] CLOSE_NONE = 2'd0;
  localparam logic [1:0] CLOSE_OPT  = 2'd1;
  localparam logic [1:0] CLOSE_PAR  = 2'd2;

  typedef enum logic [2:0] {
    CC_SPACE,
    CC_DASH,
    CC_QUOTE,
    CC_DIGIT,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    logic [7:0]  char_byte;
    char_class_t cls;
    logic        line_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] role;
    logic [1:0] item_closed;
    logic       line_done;
  } result_t;

endpackage

// ----- rtl/core/mcl_fifo.sv -----
// ----------------------------------------------------------------------------
// Command line lexer queue
// Small first-in first-out queue with full and empty flags. Depth is meant
// to stay small (up to 32 entries); entries live in registers.
// ----------------------------------------------------------------------------
module mcl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/core/mcl_front.sv -----
// ----------------------------------------------------------------------------
// Command line lexer front end
// Classifies each incoming byte as space, dash, quote, digit or other and
// forms the request that is queued for the scanner.
// ----------------------------------------------------------------------------
module mcl_front (
  input  logic          [7:0] char_byte,
  input  logic                line_last,
  output mcl_pkg::item_t      item
);

  import mcl_pkg::*;

  char_class_t cls;

  always_comb begin
    priority if (char_byte == CH_SPACE) begin
      cls = CC_SPACE;
    end else if (char_byte == CH_DASH) begin
      cls = CC_DASH;
    end else if (char_byte == CH_QUOTE) begin
      cls = CC_QUOTE;
    end else if (char_byte >= CH_ZERO && char_byte <= CH_NINE) begin
      cls = CC_DIGIT;
    end else begin
      cls = CC_OTHER;
    end
  end

  assign item.char_byte = char_byte;
  assign item.cls       = cls;
  assign item.line_last = line_last;

endmodule

// ----- rtl/core/mcl_back.sv -----
// ----------------------------------------------------------------------------
// Command line lexer back end
// Runs the lexer state machine on classified requests, one per cycle when the
// result queue has room, and pushes one tagged result per request into it.
// ----------------------------------------------------------------------------
module mcl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mcl_pkg::item_t    q_item,
  output logic              q_pop,
  input  logic              res_full,
  output logic              res_push,
  output mcl_pkg::result_t  res
);

  import mcl_pkg::*;

  typedef enum logic [3:0] {
    ST_LINE  = 4'd0,
    ST_OPER  = 4'd1,
    ST_START = 4'd2,
    ST_SOPTN = 4'd3,
    ST_SOPTP = 4'd4,
    ST_SPAR  = 4'd5,
    ST_OPTN  = 4'd6,
    ST_OPTP  = 4'd7,
    ST_OPTNQ = 4'd8,
    ST_OPTPQ = 4'd9,
    ST_PAR   = 4'd10,
    ST_PARQ  = 4'd11
  } state_t;

  typedef struct packed {
    state_t     st;
    logic [2:0] role;
    logic [1:0] closed;
  } step_t;

  // Scanner for everything after the operation name, and for a line that starts with neither a digit nor a dash.
  function automatic step_t scan_body(state_t s, char_class_t c);
    step_t o;
    o.st     = s;
    o.role   = ROLE_SKIP;
    o.closed = CLOSE_NONE;
    unique case (s)
      ST_START: begin
        if (c == CC_DASH) begin
          o.st = ST_SOPTN;
        end else if (c == CC_QUOTE) begin
          o.role = ROLE_PAR;
          o.st   = ST_PARQ;
        end else if (c != CC_SPACE) begin
          o.role = ROLE_PAR;
          o.st   = ST_PAR;
        end
      end
      ST_SOPTN: begin
        if (c == CC_SPACE) begin
          o.st = ST_START;
        end else if (c == CC_DASH) begin
          o.st = ST_SPAR;
        end else if (c == CC_QUOTE) begin
          o.role = ROLE_OPTN;
          o.st   = ST_OPTNQ;
        end else begin
          o.role = ROLE_OPTN;
          o.st   = ST_OPTN;
        end
      end
      ST_SOPTP: begin
        if (c == CC_DASH) begin
          o.closed = CLOSE_OPT;
          o.st     = ST_SOPTN;
        end else if (c == CC_QUOTE) begin
          o.role = ROLE_OPTP;
          o.st   = ST_OPTPQ;
        end else if (c != CC_SPACE) begin
          o.role = ROLE_OPTP;
          o.st   = ST_OPTP;
        end
      end
      ST_SPAR: begin
        if (c == CC_QUOTE) begin
          o.role = ROLE_PAR;
          o.st   = ST_PARQ;
        end else if (c != CC_SPACE) begin
          o.role = ROLE_PAR;
          o.st   = ST_PAR;
        end
      end
      ST_PAR: begin
        if (c == CC_SPACE) begin
          o.closed = CLOSE_PAR;
          o.st     = ST_SPAR;
        end else begin
          o.role = ROLE_PAR;
        end
      end
      ST_PARQ: begin
        o.role = ROLE_PAR;
        if (c == CC_QUOTE) begin
          o.closed = CLOSE_PAR;
          o.st     = ST_SPAR;
        end
      end
      ST_OPTN: begin
        if (c == CC_SPACE) begin
          o.st = ST_SOPTP;
        end else begin
          o.role = ROLE_OPTN;
        end
      end
      ST_OPTNQ: begin
        o.role = ROLE_OPTN;
        if (c == CC_QUOTE) begin
          o.st = ST_SOPTP;
        end
      end
      ST_OPTP: begin
        if (c == CC_SPACE) begin
          o.closed = CLOSE_OPT;
          o.st     = ST_START;
        end else begin
          o.role = ROLE_OPTP;
        end
      end
      ST_OPTPQ: begin
        o.role = ROLE_OPTP;
        if (c == CC_QUOTE) begin
          o.closed = CLOSE_OPT;
          o.st     = ST_START;
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic logic [1:0] flush_code(state_t s);
    logic [1:0] k;
    unique case (s)
      ST_OPTN, ST_OPTNQ, ST_OPTP, ST_OPTPQ, ST_SOPTP: k = CLOSE_OPT;
      ST_PAR, ST_PARQ:                                 k = CLOSE_PAR;
      default:                                         k = CLOSE_NONE;
    endcase
    return k;
  endfunction

  state_t state_r, state_nxt;
  step_t  stp;
  logic   fire;

  assign fire     = !q_empty && !res_full;
  assign q_pop    = fire;
  assign res_push = fire;

  always_comb begin
    stp.st     = state_r;
    stp.role   = ROLE_SKIP;
    stp.closed = CLOSE_NONE;
    if (state_r == ST_OPER) begin
      if (q_item.cls == CC_SPACE) begin
        stp.st = ST_START;
      end else begin
        stp.role = ROLE_OPER;
      end
    end else if (state_r >= ST_START && state_r <= ST_PARQ) begin
      stp = scan_body(state_r, q_item.cls);
    end else if (q_item.cls == CC_DIGIT) begin
      stp.role = ROLE_TOKEN;
      stp.st   = ST_LINE;
    end else if (q_item.cls == CC_DASH) begin
      stp.role = ROLE_OPER;
      stp.st   = ST_OPER;
    end else begin
      stp = scan_body(ST_START, q_item.cls);
    end

    state_nxt       = stp.st;
    res.out_byte    = q_item.char_byte;
    res.role        = stp.role;
    res.item_closed = stp.closed;
    res.line_done   = q_item.line_last;
    if (q_item.line_last) begin
      if (stp.closed == CLOSE_NONE) begin
        res.item_closed = flush_code(stp.st);
      end
      state_nxt = ST_LINE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LINE;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/mi_command_line_lexer_top.sv -----
// ----------------------------------------------------------------------------
// Command line lexer top level
// Tags each byte of a command line with its role and reports completed
// options and parameters.
//
//   Channel  Direction  Handshake         Payload
//   in_      request    in_push/in_full   in_char_byte, in_line_last
//   out_     result     out_pop/out_empty out_out_byte, out_role,
//                                         out_item_closed, out_line_done
//
// One request per cycle sustained while results are popped; each request is
// registered in the request queue, its result in the result queue. The rate
// is set by the scanner, which updates its state once per accepted request.
// Reset is synchronous and empties both queues; the lexer returns to line start.
// A stalled result side fills the result queue, then the request queue,
// and only then raises in_full.
// ----------------------------------------------------------------------------
module mi_command_line_lexer_top #(
  parameter int IN_DEPTH  = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char_byte,
  input  logic       in_line_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_out_byte,
  output logic [2:0] out_role,
  output logic [1:0] out_item_closed,
  output logic       out_line_done
);

  import mcl_pkg::*;

  item_t   front_item;
  item_t   q_item;
  logic    q_empty, q_pop;
  result_t res_in, res_out;
  logic    res_push, res_full;

  mcl_front u_front (
    .char_byte (in_char_byte),
    .line_last (in_line_last),
    .item      (front_item)
  );

  mcl_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (IN_DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_item),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  mcl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  mcl_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_out_byte    = res_out.out_byte;
  assign out_role        = res_out.role;
  assign out_item_closed = res_out.item_closed;
  assign out_line_done   = res_out.line_done;

endmodule

// ----- rtl/core/mcl_checker.sv -----
// ----------------------------------------------------------------------------
// Command line lexer checker
// Port-level properties of the command line lexer, bound to the top level.
// ----------------------------------------------------------------------------
module mcl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_out_byte,
  input logic [2:0] out_role,
  input logic [1:0] out_item_closed
);

  import mcl_pkg::*;

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting right after reset");

  // A waiting result carries a defined role and completion code.
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_role <= ROLE_PAR) && (out_item_closed != 2'd3))
    else $error("undefined role or completion code");

  // Token digits never complete an option or a parameter.
  a_token_close: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_role == ROLE_TOKEN) |-> (out_item_closed == CLOSE_NONE))
    else $error("token byte reports a completion");

  // A closing quote of a quoted parameter is tagged as part of it.
  a_quote_role: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item_closed == CLOSE_PAR && out_out_byte == CH_QUOTE)
      |-> (out_role == ROLE_PAR))
    else $error("closing quote not tagged as parameter");

  // A result that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_out_byte)))
    else $error("stalled result changed");

endmodule

bind mi_command_line_lexer_top mcl_checker u_mcl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_out_byte    (out_out_byte),
  .out_role        (out_role),
  .out_item_closed (out_item_closed)
);
